// ===== hdl/rpp_pkg.sv =====
package rpp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int CX_W           = 12;
    localparam int SIZE_W         = 10;
    localparam int ZOOM_W         = 16;
    localparam int CFG_W          = 16;
    localparam int TRIG_W         = 16;
    localparam int RANGE_W        = SIZE_W + ZOOM_W + 7;
    localparam int Q_W            = SIZE_W;
    localparam int MARK_W         = 14;
    localparam int COLOR_W        = 32;
    localparam int DIV_CELLS      = Q_W;

    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [16:0] SIN_B = 17'd42048;
    localparam logic [16:0] SIN_C = 17'd4640;

    typedef enum logic [1:0] {
        REG_CENTER_X  = 2'd0,
        REG_CENTER_Y  = 2'd1,
        REG_HALF_SIZE = 2'd2,
        REG_ZOOM      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic               fix_x;
        logic               fix_y;
        logic               zero;
        logic [COLOR_W-1:0] color;
    } t_side;

endpackage

// ===== hdl/rpp_sine.sv =====
module rpp_sine
    import rpp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [17:0]              i_ang,
    output logic signed [TRIG_W-1:0] o_sin
);

    logic [16:0] r_z1, r_z2, r_z3, r_zz, r_zz2;
    logic [16:0] r_t, r_t2;
    logic        r_neg1, r_neg2, r_neg3;
    logic [16:0] n_z;
    logic [33:0] n_zsq, n_ct, n_zt, n_zs;
    logic [17:0] n_q;

    always_comb begin
        n_z   = i_ang[16] ? 17'(17'd65536 - {1'b0, i_ang[15:0]}) : {1'b0, i_ang[15:0]};
        n_zsq = {17'b0, n_z} * {17'b0, n_z};
        n_ct  = {17'b0, SIN_C} * {17'b0, r_zz};
        n_zt  = {17'b0, r_zz2} * {17'b0, r_t};
        n_zs  = {17'b0, r_z3} * {17'b0, r_t2};
        n_q   = 18'((n_zs >> 16) + 34'd1) >> 1;
        if (n_q > 18'd32767) begin
            n_q = 18'd32767;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1   <= n_z;
            r_zz   <= 17'(n_zsq >> 16);
            r_neg1 <= i_ang[17];
            r_z2   <= r_z1;
            r_zz2  <= r_zz;
            r_t    <= SIN_B - 17'(n_ct >> 16);
            r_neg2 <= r_neg1;
            r_z3   <= r_z2;
            r_t2   <= SIN_A - 17'(n_zt >> 16);
            r_neg3 <= r_neg2;
            o_sin  <= r_neg3 ? -TRIG_W'(n_q) : TRIG_W'(n_q);
        end
    end

    // z squared travels one more stage so the third product stays with its item

endmodule

// ===== hdl/rpp_div_cell.sv =====
module rpp_div_cell
    import rpp_pkg::*;
#(
    parameter int NUM_W = 44,
    parameter int DEN_W = 34,
    parameter int BIT   = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_rem,
    input  logic [DEN_W-1:0] i_den,
    input  logic [Q_W-1:0]   i_q,
    output logic [NUM_W-1:0] o_rem,
    output logic [DEN_W-1:0] o_den,
    output logic [Q_W-1:0]   o_q
);

    logic [NUM_W-1:0] n_trial;
    logic             n_take;
    logic [Q_W-1:0]   n_q;

    always_comb begin
        n_trial  = NUM_W'(i_den) << BIT;
        n_take   = (i_rem >= n_trial);
        n_q      = i_q;
        n_q[BIT] = n_take;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_take ? (i_rem - n_trial) : i_rem;
            o_den <= i_den;
            o_q   <= n_q;
        end
    end

endmodule

// ===== hdl/radar_point_projector_core.sv =====
// channel   | dir | fields (lowest bit up)
// s_axis    | in  | target_x, target_y, viewer_x, viewer_y, view_yaw, marker_color
// m_axis    | out | marker_left, marker_top, marker_color_out
// i_cfg_*   | in  | write enable, register index 0..3, write data
// one item per cycle when not stalled; the stages are 4 sine stages, product, sum, select,
// one restoring divider cell per quotient bit (10) and the output register
// the whole pipeline moves together; it stalls only while a result waits
// reset clears the valid bits and loads the register defaults
module radar_point_projector_core
    import rpp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // target_x, target_y, viewer_x, viewer_y, view_yaw, marker_color
    input  logic [((4*COORD_BITS+ANGLE_BITS+COLOR_W+7)/8)*8-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // marker_left, marker_top, marker_color_out
    output logic [63:0]      m_axis_tdata,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int W     = COORD_BITS;
    localparam int DXW   = W + 1;
    localparam int PW    = W + 17;
    localparam int XW    = W + 18;
    localparam int DW    = (XW > RANGE_W) ? XW : RANGE_W;
    localparam int NW    = DW + SIZE_W;
    localparam int NST   = 7 + DIV_CELLS + 1;
    localparam int Y_LO  = W;
    localparam int VX_LO = 2 * W;
    localparam int VY_LO = 3 * W;
    localparam int A_LO  = 4 * W;
    localparam int C_LO  = 4 * W + ANGLE_BITS;

    logic [CX_W-1:0]    r_center_x, r_center_y;
    logic [SIZE_W-1:0]  r_size;
    logic [ZOOM_W-1:0]  r_zoom;
    logic [RANGE_W-1:0] r_range;
    logic [NST-1:0]     r_vld;
    logic               en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= CX_W'(100);
            r_center_y <= CX_W'(100);
            r_size     <= SIZE_W'(100);
            r_zoom     <= ZOOM_W'(256);
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CENTER_X:  r_center_x <= i_cfg_wdata[CX_W-1:0];
                REG_CENTER_Y:  r_center_y <= i_cfg_wdata[CX_W-1:0];
                REG_HALF_SIZE: r_size     <= i_cfg_wdata[SIZE_W-1:0];
                REG_ZOOM:      r_zoom     <= i_cfg_wdata[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_range <= RANGE_W'({16'b0, r_size} * {10'b0, r_zoom}) << 7;
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // yaw as a 32-bit turn, cosine a quarter turn ahead
    logic [31:0] a_sin, a_cos;
    logic signed [TRIG_W-1:0] sn, cs;

    assign a_sin = 32'(s_axis_tdata[A_LO +: ANGLE_BITS]) << (32 - ANGLE_BITS);
    assign a_cos = a_sin + 32'h4000_0000;

    rpp_sine u_sin (.i_clk(i_clk), .i_en(en), .i_ang(a_sin[31:14]), .o_sin(sn));
    rpp_sine u_cos (.i_clk(i_clk), .i_en(en), .i_ang(a_cos[31:14]), .o_sin(cs));

    logic signed [DXW-1:0] r_dx [0:3];
    logic signed [DXW-1:0] r_dy [0:3];
    logic [COLOR_W-1:0]    r_col [0:5];
    logic signed [W-1:0]   tx, ty, vx, vy;

    assign tx = s_axis_tdata[0 +: W];
    assign ty = s_axis_tdata[Y_LO +: W];
    assign vx = s_axis_tdata[VX_LO +: W];
    assign vy = s_axis_tdata[VY_LO +: W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx[0]  <= DXW'(tx) - DXW'(vx);
            r_dy[0]  <= DXW'(ty) - DXW'(vy);
            r_col[0] <= s_axis_tdata[C_LO +: COLOR_W];
            for (int k = 1; k < 4; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
            for (int k = 1; k < 6; k++) begin
                r_col[k] <= r_col[k-1];
            end
        end
    end

    // rotation products, then sums
    logic signed [PW-1:0] r_pxs, r_pyc, r_pxc, r_pys;
    logic signed [XW-1:0] r_x, r_y;
    logic [XW-1:0]        r_ax, r_ay;
    logic signed [XW-1:0] n_x, n_y;

    always_comb begin
        n_x = XW'(r_pxs) - XW'(r_pyc);
        n_y = -XW'(r_pxc) - XW'(r_pys);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxs <= PW'(r_dx[3]) * PW'(sn);
            r_pyc <= PW'(r_dy[3]) * PW'(cs);
            r_pxc <= PW'(r_dx[3]) * PW'(cs);
            r_pys <= PW'(r_dy[3]) * PW'(sn);
            r_x   <= n_x;
            r_y   <= n_y;
            r_ax  <= n_x[XW-1] ? XW'(-n_x) : XW'(n_x);
            r_ay  <= n_y[XW-1] ? XW'(-n_y) : XW'(n_y);
        end
    end

    // edge or inside selection, numerators scaled by size
    logic [NW-1:0]  w_rem_x [0:DIV_CELLS];
    logic [NW-1:0]  w_rem_y [0:DIV_CELLS];
    logic [DW-1:0]  w_den_x [0:DIV_CELLS];
    logic [DW-1:0]  w_den_y [0:DIV_CELLS];
    logic [Q_W-1:0] w_q_x   [0:DIV_CELLS];
    logic [Q_W-1:0] w_q_y   [0:DIV_CELLS];
    t_side          r_side  [0:DIV_CELLS];
    t_side          n_side;
    logic           outside, y_gt_x, y_gt_nx;
    logic signed [XW:0] sum_xy;

    always_comb begin
        sum_xy  = (XW+1)'(r_x) + (XW+1)'(r_y);
        y_gt_x  = r_y > r_x;
        y_gt_nx = sum_xy > 0;
        outside = (DW'(r_ax) > DW'(r_range)) || (DW'(r_ay) > DW'(r_range));
        n_side.neg_x = r_x[XW-1];
        n_side.neg_y = r_y[XW-1];
        n_side.fix_y = outside && (y_gt_x == y_gt_nx);
        n_side.fix_x = outside && (y_gt_x != y_gt_nx);
        n_side.zero  = (r_range == '0);
        n_side.color = r_col[5];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            w_rem_x[0] <= NW'({{(NW-XW){1'b0}}, r_ax} * {{(NW-SIZE_W){1'b0}}, r_size});
            w_rem_y[0] <= NW'({{(NW-XW){1'b0}}, r_ay} * {{(NW-SIZE_W){1'b0}}, r_size});
            w_den_x[0] <= outside ? DW'(r_ay) : DW'(r_range);
            w_den_y[0] <= outside ? DW'(r_ax) : DW'(r_range);
            w_q_x[0]   <= '0;
            w_q_y[0]   <= '0;
            r_side[0]  <= n_side;
            for (int k = 1; k <= DIV_CELLS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
        rpp_div_cell #(.NUM_W(NW), .DEN_W(DW), .BIT(Q_W - 1 - k)) u_cx (
            .i_clk(i_clk), .i_en(en),
            .i_rem(w_rem_x[k]), .i_den(w_den_x[k]), .i_q(w_q_x[k]),
            .o_rem(w_rem_x[k+1]), .o_den(w_den_x[k+1]), .o_q(w_q_x[k+1])
        );
        rpp_div_cell #(.NUM_W(NW), .DEN_W(DW), .BIT(Q_W - 1 - k)) u_cy (
            .i_clk(i_clk), .i_en(en),
            .i_rem(w_rem_y[k]), .i_den(w_den_y[k]), .i_q(w_q_y[k]),
            .o_rem(w_rem_y[k+1]), .o_den(w_den_y[k+1]), .o_q(w_q_y[k+1])
        );
    end

    // offsets, centre and corner
    t_side                  fin;
    logic [Q_W-1:0]         mag_x, mag_y;
    logic signed [MARK_W-1:0] off_x, off_y;

    always_comb begin
        fin   = r_side[DIV_CELLS];
        mag_x = fin.fix_x ? r_size : w_q_x[DIV_CELLS];
        mag_y = fin.fix_y ? r_size : w_q_y[DIV_CELLS];
        off_x = fin.neg_x ? -MARK_W'(mag_x) : MARK_W'(mag_x);
        off_y = fin.neg_y ? -MARK_W'(mag_y) : MARK_W'(mag_y);
        if (fin.zero) begin
            off_x = '0;
            off_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= {4'b0, fin.color,
                             MARK_W'(MARK_W'(r_center_y) + off_y - MARK_W'(1)),
                             MARK_W'(MARK_W'(r_center_x) + off_x - MARK_W'(1))};
        end
    end

`ifndef NO_ASSERTIONS
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_range == '0 && $stable(r_center_x)
        |-> m_axis_tdata[MARK_W-1:0] == MARK_W'(MARK_W'(r_center_x) - MARK_W'(1)))
        else $error("zero range marker off centre");
`endif

endmodule

// ===== dv/tb_radar_point_projector_core.sv =====
module tb_radar_point_projector_core;
    import rpp_pkg::*;

    localparam int  IN_W      = ((4*16+16+COLOR_W+7)/8)*8;
    localparam int  CYC_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic [15:0]        yaw;
        logic [31:0]        color;
    } t_point;

    typedef struct {
        logic [13:0] left;
        logic [13:0] top;
        logic [31:0] color;
    } t_marker;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [63:0]       m_axis_tdata;
    logic              i_cfg_wr_en;
    logic [1:0]        i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_wdata;

    // register copies
    int unsigned cx_q, cy_q, size_q, zoom_q;

    t_point  pending_points[$];
    t_marker expected_markers[$];
    t_point  point_on_bus;
    int      send_idle_pct, recv_idle_pct;
    int      mismatches, checked, cycles;

    radar_point_projector_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // quarter-wave sine polynomial, z in Q16, result Q1.15
    function automatic longint quarter_wave(longint z);
        longint z2, t, t2, s, q;
        z2 = (z * z) >>> 16;
        t  = longint'(SIN_B) - ((longint'(SIN_C) * z2) >>> 16);
        t2 = longint'(SIN_A) - ((z2 * t) >>> 16);
        s  = (z * t2) >>> 16;
        q  = (s + 1) >>> 1;
        return (q > 32767) ? 32767 : q;
    endfunction

    function automatic longint turn_sine(logic [31:0] a);
        longint z, v;
        z = longint'(a[29:14]);
        v = quarter_wave(a[30] ? 65536 - z : z);
        return a[31] ? -v : v;
    endfunction

    function automatic t_marker project_point(t_point p);
        t_marker m;
        logic [31:0] a;
        longint sn, cs, dx, dy, x, y, sz, r, ox, oy, ax, ay;
        a  = {p.yaw, 16'h0000};
        sn = turn_sine(a);
        cs = turn_sine(a + 32'h4000_0000);
        dx = longint'(p.tx) - longint'(p.vx);
        dy = longint'(p.ty) - longint'(p.vy);
        x  = dx * sn - dy * cs;
        y  = -dx * cs - dy * sn;
        sz = longint'(size_q);
        r  = longint'(size_q) * longint'(zoom_q) * 128;
        ox = 0;
        oy = 0;
        if (r > 0) begin
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            if (ax > r || ay > r) begin
                if (y > x) begin
                    if (y > -x) begin
                        ox = sz * x / y;
                        oy = sz;
                    end else begin
                        ox = -sz;
                        oy = -sz * y / x;
                    end
                end else begin
                    if (y > -x) begin
                        ox = sz;
                        oy = sz * y / x;
                    end else begin
                        ox = -sz * x / y;
                        oy = -sz;
                    end
                end
            end else begin
                ox = x * sz / r;
                oy = y * sz / r;
            end
        end
        m.left  = 14'(longint'(cx_q) + ox - 1);
        m.top   = 14'(longint'(cy_q) + oy - 1);
        m.color = p.color;
        return m;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_markers.push_back(project_point(point_on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    point_on_bus = pending_points.pop_front();
                    s_axis_tdata <= {point_on_bus.color, point_on_bus.yaw, point_on_bus.vy,
                                     point_on_bus.vx, point_on_bus.ty, point_on_bus.tx};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_marker want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                checked++;
                if (expected_markers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item %h", m_axis_tdata);
                end else begin
                    want = expected_markers.pop_front();
                    if (m_axis_tdata[13:0] !== want.left || m_axis_tdata[27:14] !== want.top
                        || m_axis_tdata[59:28] !== want.color) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected left %0d top %0d colour %h, got %0d %0d %h",
                                     $signed(want.left), $signed(want.top), want.color,
                                     $signed(m_axis_tdata[13:0]), $signed(m_axis_tdata[27:14]),
                                     m_axis_tdata[59:28]);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout with %0d items outstanding", expected_markers.size());
            $display("FAIL radar_point_projector_core");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        case (idx)
            REG_CENTER_X:  cx_q   = v & 16'h0FFF;
            REG_CENTER_Y:  cy_q   = v & 16'h0FFF;
            REG_HALF_SIZE: size_q = v & 16'h03FF;
            REG_ZOOM:      zoom_q = v;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(logic [15:0] cx, logic [15:0] cy, logic [15:0] sz, logic [15:0] zm);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_HALF_SIZE, sz);
        write_reg(REG_ZOOM, zm);
    endtask

    task automatic add_point(int tx, int ty, int vx, int vy, int yaw, logic [31:0] col);
        t_point p;
        p.tx    = 16'(tx);
        p.ty    = 16'(ty);
        p.vx    = 16'(vx);
        p.vy    = 16'(vy);
        p.yaw   = 16'(yaw);
        p.color = col;
        pending_points.push_back(p);
    endtask

    task automatic add_random_points(int n);
        int span, vx, vy, ox, oy, kind;
        span = (size_q * zoom_q) >> 8;
        span = (span > 16000) ? 32000 : 2 * span + 8;
        repeat (n) begin
            vx   = $urandom_range(65535) - 32768;
            vy   = $urandom_range(65535) - 32768;
            kind = $urandom_range(9);
            ox   = $urandom_range(2 * span) - span;
            oy   = $urandom_range(2 * span) - span;
            if (kind < 5)
                add_point(vx + ox, vy + oy, vx, vy, $urandom, $urandom);
            else if (kind < 6)
                add_point(vx + ox, vy + (kind[0] ? ox : -ox), vx, vy,
                          $urandom_range(3) * 16384, $urandom);
            else
                add_point($urandom, $urandom, vx, vy, $urandom, $urandom);
        end
    endtask

    task automatic drain;
        while (pending_points.size() > 0 || s_axis_tvalid || expected_markers.size() > 0)
            @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = REG_CENTER_X;
        i_cfg_wdata   = '0;
        cx_q = 100; cy_q = 100; size_q = 100; zoom_q = 256;
        mismatches = 0; checked = 0; cycles = 0;
        send_idle_pct = 29;
        recv_idle_pct = 54;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed points, reset registers
        add_point(0, 0, 0, 0, 0, 32'h0000_0000);
        add_point(32767, 32767, -32768, -32768, 0, 32'hFFFF_FFFF);
        add_point(-32768, -32768, 32767, 32767, 16'hFFFF, 32'hA5A5_5A5A);
        add_point(32767, -32768, -32768, 32767, 16'h4000, 32'h5A5A_A5A5);
        add_point(-32768, 32767, 32767, -32768, 16'h8000, 32'h1234_5678);
        add_point(50, 0, 0, 0, 16'hC000, 32'h8000_0001);
        add_point(0, 50, 0, 0, 16'h0000, 1);
        add_point(-99, 0, 0, 0, 16'h2000, 2);
        add_point(99, 99, 0, 0, 16'h0000, 3);
        add_point(500, 500, 0, 0, 16'h0000, 4);
        add_point(500, -500, 0, 0, 16'h0000, 5);
        add_point(-500, 500, 0, 0, 16'h0000, 6);
        add_point(-500, -500, 0, 0, 16'h0000, 7);
        add_point(1000, 10, 0, 0, 16'h0000, 8);
        add_point(10, -1000, 0, 0, 16'h0000, 9);
        add_point(100, 0, 0, 0, 16'h0000, 10);
        add_point(101, 0, 0, 0, 16'h0000, 11);
        add_point(-7, 13, 0, 0, 16'h7FFF, 12);
        add_point(300, 1, 0, 0, 16'h0001, 13);
        add_random_points(100);
        drain();

        set_regs(16'h0FFF, 16'h0000, 16'd1023, 16'hFFFF);
        add_random_points(115);
        drain();

        set_regs(16'hF123, 16'hF800, 16'hFC00, 16'd300);
        add_point(32767, 32767, -32768, -32768, 16'h1234, 32'hFFFF_FFFF);
        add_random_points(110);
        drain();

        send_idle_pct = 54;
        recv_idle_pct = 29;
        set_regs(16'h0000, 16'h0FFF, 16'd1, 16'd1);
        add_random_points(115);
        drain();

        set_regs(16'd2000, 16'd1500, 16'd1023, 16'd256);
        add_random_points(115);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(16'd640, 16'd480, 16'd50, 16'd0);
        add_random_points(110);
        drain();

        set_regs(16'd320, 16'd240, 16'd200, 16'd4);
        add_random_points(115);
        drain();

        $display("checked %0d markers over seven register settings, incl. zero range", checked);
        $display("and extreme centre, size and zoom, under three handshake idling mixes");
        if (mismatches == 0 && expected_markers.size() == 0) begin
            $display("PASS radar_point_projector_core");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL radar_point_projector_core");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rpp_pkg.sv
hdl/rpp_sine.sv
hdl/rpp_div_cell.sv
hdl/radar_point_projector_core.sv
dv/tb_radar_point_projector_core.sv
